// File: design/cac_pkg.sv
// Shared types and constants for the card armed alarm controller.
// Used by every module of the block; depends on nothing.
package cac_pkg;

  // Action codes carried by an input item.
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_CARD    = 3'd1;
  localparam logic [2:0] ACT_TRIGGER = 3'd2;
  localparam logic [2:0] ACT_ARM     = 3'd3;
  localparam logic [2:0] ACT_DISARM  = 3'd4;
  localparam logic [2:0] ACT_ENROL   = 3'd5;
  localparam logic [2:0] ACT_CLEAR   = 3'd6;

  // Result status codes.
  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_DONE      = 3'd1;
  localparam logic [2:0] ST_REFUSED   = 3'd2;
  localparam logic [2:0] ST_KNOWN     = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;
  localparam logic [2:0] ST_ENROLLED  = 3'd5;
  localparam logic [2:0] ST_DUPLICATE = 3'd6;
  localparam logic [2:0] ST_FULL      = 3'd7;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BUZZER  = 2'd0;
  localparam logic [1:0] CFG_LOCK    = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

  // Operation after classification by the front end.
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_CARD    = 3'd1,
    OP_TRIGGER = 3'd2,
    OP_ARM     = 3'd3,
    OP_DISARM  = 3'd4,
    OP_ENROL   = 3'd5,
    OP_CLEAR   = 3'd6,
    OP_NONE    = 3'd7
  } op_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] card_code;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       armed_now;
    logic       ringing_now;
    logic       relay_on;
    logic       enrolling_now;
    logic [4:0] cards_held;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] code;
  } cmd_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

// File: design/cac_front.sv
// Front end of the alarm controller: accepts input items, classifies the
// action code and holds the commands in a two-entry queue. Uses cac_pkg.
module cac_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cac_pkg::in_item_t    in_data,
  output cac_pkg::queue_head_t head,
  input  logic                 pop
);

  cac_pkg::cmd_t q_mem [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    fill_r, fill_nxt;
  logic          push;
  cac_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.code = in_data.card_code;
    case (in_data.action)
      cac_pkg::ACT_TICK:    cmd_in.op = cac_pkg::OP_TICK;
      cac_pkg::ACT_CARD:    cmd_in.op = cac_pkg::OP_CARD;
      cac_pkg::ACT_TRIGGER: cmd_in.op = cac_pkg::OP_TRIGGER;
      cac_pkg::ACT_ARM:     cmd_in.op = cac_pkg::OP_ARM;
      cac_pkg::ACT_DISARM:  cmd_in.op = cac_pkg::OP_DISARM;
      cac_pkg::ACT_ENROL:   cmd_in.op = cac_pkg::OP_ENROL;
      cac_pkg::ACT_CLEAR:   cmd_in.op = cac_pkg::OP_CLEAR;
      default:              cmd_in.op = cac_pkg::OP_NONE;
    endcase
  end

  assign in_ready   = (fill_r != 2'd2);
  assign push       = in_valid && in_ready;
  assign head.valid = (fill_r != 2'd0);
  assign head.cmd   = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// File: design/cac_back.sv
// Back end of the alarm controller: configuration registers, alarm state,
// the card list memory with its serial lookup, and the result register.
// Uses cac_pkg.
module cac_back #(
  parameter int MAX_CARDS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cac_pkg::queue_head_t head,
  output logic                 pop,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cac_pkg::out_item_t   out_data
);

  localparam int CW = $clog2(MAX_CARDS + 1);
  localparam int AW = (MAX_CARDS > 1) ? $clog2(MAX_CARDS) : 1;
  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_CARDS);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic        buzzer_r, lock_r;
  logic [15:0] timeout_r;

  logic          armed_r, armed_nxt;
  logic          ringing_r, ringing_nxt;
  logic          enrolling_r, enrolling_nxt;
  logic          relay_r, relay_nxt;
  logic [15:0]   elapsed_r, elapsed_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic [31:0]   card_mem [MAX_CARDS];
  logic [31:0]   rd_data_r;
  logic          rd_v_r, rd_v_nxt;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic          hit_r, hit_nxt;
  logic [31:0]   code_r;

  logic               out_valid_r;
  cac_pkg::out_item_t out_item_r;

  logic          slot_free;
  logic          start_scan;
  logic          fire;
  cac_pkg::op_t  ex_op;
  logic [31:0]   ex_code;
  logic          ex_hit;
  logic [2:0]    status;
  logic          mem_we;
  logic          issue;
  logic [15:0]   elapsed_inc;

  assign slot_free  = !out_valid_r || out_ready;
  assign start_scan = (state_r == S_IDLE) && head.valid &&
                      (head.cmd.op == cac_pkg::OP_CARD) && !lock_r;
  assign fire       = ((state_r == S_IDLE) && head.valid && !start_scan && slot_free) ||
                      ((state_r == S_FINISH) && slot_free);
  assign pop        = start_scan ||
                      ((state_r == S_IDLE) && head.valid && slot_free);
  assign issue      = (scan_idx_r < count_r);

  assign ex_op   = (state_r == S_FINISH) ? cac_pkg::OP_CARD : head.cmd.op;
  assign ex_code = (state_r == S_FINISH) ? code_r : head.cmd.code;
  assign ex_hit  = hit_r;

  assign elapsed_inc = (elapsed_r != cac_pkg::ELAPSED_MAX) ? elapsed_r + 16'd1 : elapsed_r;

  // Effect of one action on the alarm state.
  always_comb begin
    armed_nxt     = armed_r;
    ringing_nxt   = ringing_r;
    enrolling_nxt = enrolling_r;
    relay_nxt     = relay_r;
    elapsed_nxt   = elapsed_r;
    count_nxt     = count_r;
    status        = cac_pkg::ST_NONE;
    mem_we        = 1'b0;
    case (ex_op)
      cac_pkg::OP_TICK: begin
        if (!lock_r && ringing_r) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= timeout_r) begin
            ringing_nxt = 1'b0;
            if (buzzer_r) begin
              relay_nxt = 1'b0;
            end
            status = cac_pkg::ST_DONE;
          end
        end
      end
      cac_pkg::OP_CARD: begin
        if (lock_r) begin
          status = cac_pkg::ST_REFUSED;
        end else if (enrolling_r) begin
          enrolling_nxt = 1'b0;
          if (ex_hit) begin
            status = cac_pkg::ST_DUPLICATE;
          end else if (count_r >= COUNT_FULL) begin
            status = cac_pkg::ST_FULL;
          end else begin
            mem_we    = 1'b1;
            count_nxt = count_r + CW'(1);
            status    = cac_pkg::ST_ENROLLED;
          end
        end else if (ex_hit) begin
          status = cac_pkg::ST_KNOWN;
          if (ringing_r) begin
            ringing_nxt = 1'b0;
            if (buzzer_r) begin
              relay_nxt = 1'b0;
            end
          end else begin
            armed_nxt = !armed_r;
          end
        end else begin
          status = cac_pkg::ST_UNKNOWN;
        end
      end
      cac_pkg::OP_TRIGGER: begin
        if (ringing_r) begin
          elapsed_nxt = 16'd0;
          status      = cac_pkg::ST_DONE;
        end else if (!armed_r && (lock_r || enrolling_r)) begin
          status = cac_pkg::ST_REFUSED;
        end else begin
          armed_nxt   = 1'b1;
          ringing_nxt = 1'b1;
          elapsed_nxt = 16'd0;
          if (buzzer_r) begin
            relay_nxt = 1'b1;
          end
          status = cac_pkg::ST_DONE;
        end
      end
      cac_pkg::OP_ARM: begin
        if (lock_r || enrolling_r) begin
          status = cac_pkg::ST_REFUSED;
        end else if (!armed_r) begin
          armed_nxt = 1'b1;
          status    = cac_pkg::ST_DONE;
        end
      end
      cac_pkg::OP_DISARM: begin
        if (lock_r) begin
          status = cac_pkg::ST_REFUSED;
        end else if (armed_r) begin
          armed_nxt   = 1'b0;
          ringing_nxt = 1'b0;
          if (ringing_r && buzzer_r) begin
            relay_nxt = 1'b0;
          end
          status = cac_pkg::ST_DONE;
        end
      end
      cac_pkg::OP_ENROL: begin
        if (lock_r || armed_r || enrolling_r) begin
          status = cac_pkg::ST_REFUSED;
        end else begin
          enrolling_nxt = 1'b1;
          status        = cac_pkg::ST_DONE;
        end
      end
      cac_pkg::OP_CLEAR: begin
        count_nxt = '0;
        status    = cac_pkg::ST_DONE;
      end
      default: begin
        status = cac_pkg::ST_NONE;
      end
    endcase
  end

  // Lookup sequencer: one memory read is issued per cycle and compared on
  // the following cycle, until a match is found or the list is exhausted.
  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    rd_v_nxt     = 1'b0;
    hit_nxt      = hit_r;
    case (state_r)
      S_IDLE: begin
        if (start_scan) begin
          state_nxt    = S_SCAN;
          scan_idx_nxt = '0;
          hit_nxt      = 1'b0;
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_v_nxt     = 1'b1;
          scan_idx_nxt = scan_idx_r + CW'(1);
        end
        if (rd_v_r && (rd_data_r == code_r)) begin
          hit_nxt   = 1'b1;
          state_nxt = S_FINISH;
        end else if (!issue && !rd_v_r) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_idx_r  <= '0;
      rd_v_r      <= 1'b0;
      hit_r       <= 1'b0;
      buzzer_r    <= 1'b1;
      lock_r      <= 1'b0;
      timeout_r   <= cac_pkg::TIMEOUT_RESET;
      armed_r     <= 1'b0;
      ringing_r   <= 1'b0;
      enrolling_r <= 1'b0;
      relay_r     <= 1'b0;
      elapsed_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
      rd_v_r     <= (state_r == S_SCAN) ? rd_v_nxt : 1'b0;
      hit_r      <= hit_nxt;
      if (cfg_we) begin
        case (cfg_index)
          cac_pkg::CFG_BUZZER:  buzzer_r  <= cfg_wdata[0];
          cac_pkg::CFG_LOCK:    lock_r    <= cfg_wdata[0];
          cac_pkg::CFG_TIMEOUT: timeout_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (fire) begin
        armed_r     <= armed_nxt;
        ringing_r   <= ringing_nxt;
        enrolling_r <= enrolling_nxt;
        relay_r     <= relay_nxt;
        elapsed_r   <= elapsed_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers and the card list memory.
  always_ff @(posedge clk) begin
    if (start_scan) begin
      code_r <= head.cmd.code;
    end
    if ((state_r == S_SCAN) && issue) begin
      rd_data_r <= card_mem[scan_idx_r[AW-1:0]];
    end
    if (fire && mem_we) begin
      card_mem[count_r[AW-1:0]] <= ex_code;
    end
    if (fire) begin
      out_item_r.status        <= status;
      out_item_r.armed_now     <= armed_nxt;
      out_item_r.ringing_now   <= ringing_nxt;
      out_item_r.relay_on      <= relay_nxt;
      out_item_r.enrolling_now <= enrolling_nxt;
      out_item_r.cards_held    <= 5'(count_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

// File: design/card_armed_alarm_controller_unit.sv
// Card armed alarm controller: one result item for every action item.
// Command queue front end (cac_front) feeding the execution back end (cac_back).
//
// Usage:
//   in_valid/in_ready/in_data carry actions (tick, card read, trigger, arm,
//   disarm, start enrolment, clear list) with a 32-bit card code.
//   out_valid/out_ready/out_data return one status item per action, with the
//   alarm state and the number of listed cards after that action.
//   cfg_we/cfg_index/cfg_wdata write buzzer_enable (0), lock_all (1) and
//   ring_timeout_ticks (2); write them only while no item is in flight.
// Execution:
//   Every action other than an unlocked card read is executed straight from
//   the queue head, one per back-end cycle while the result register is free.
//   An unlocked card read walks the card list serially through the memory's
//   single read port, one entry at a time, stopping at the first match.
// Reset: the alarm is disarmed, silent, not enrolling, with an empty list;
//   registers return to buzzer on, unlocked and a 5000-tick timeout.
// Stall: the result register holds while out_ready is low; the two-entry
//   queue keeps taking actions until it fills, then in_ready drops.
module card_armed_alarm_controller_unit #(
  parameter int MAX_CARDS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cac_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cac_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  cac_pkg::queue_head_t head;
  logic                 pop;

  cac_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .head     (head),
    .pop      (pop)
  );

  cac_back #(
    .MAX_CARDS (MAX_CARDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: tb/sv/cac_alarm_checker.sv
// Result checker for the card armed alarm controller: tracks register writes,
// predicts one status item per input transfer and compares output transfers.
// Depends on cac_pkg for the payload structs, action, status and register codes.
module cac_alarm_checker #(
  parameter int MAX_CARDS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  cac_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  cac_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output int                 errors,
  output int                 queued
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        buzzer_on;
  logic        locked;
  logic [15:0] ring_limit;

  logic        armed;
  logic        ringing;
  logic        enrolling;
  logic        relay;
  logic [15:0] ring_count;
  logic [4:0]  n_cards;
  logic [31:0] cards [MAX_CARDS];

  cac_pkg::out_item_t pending_status [$];
  cac_pkg::out_item_t predicted;
  cac_pkg::out_item_t oldest;

  function automatic logic is_listed(input logic [31:0] code);
    int i;
    is_listed = 1'b0;
    for (i = 0; i < n_cards; i++)
      if (cards[i] == code) is_listed = 1'b1;
  endfunction

  // The relay only follows the end of ringing while the buzzer is enabled.
  task automatic silence();
    if (ringing) begin
      if (buzzer_on) relay = 1'b0;
      ringing = 1'b0;
    end
  endtask

  task automatic apply_action(input cac_pkg::in_item_t it, output cac_pkg::out_item_t res);
    logic [2:0] st;
    st = cac_pkg::ST_NONE;
    case (it.action)
      cac_pkg::ACT_TICK: begin
        if (!locked && ringing) begin
          if (ring_count != cac_pkg::ELAPSED_MAX) ring_count++;
          if (ring_count >= ring_limit) begin
            silence();
            st = cac_pkg::ST_DONE;
          end
        end
      end
      cac_pkg::ACT_CARD: begin
        if (locked) begin
          st = cac_pkg::ST_REFUSED;
        end else if (enrolling) begin
          enrolling = 1'b0;
          if (is_listed(it.card_code)) begin
            st = cac_pkg::ST_DUPLICATE;
          end else if (n_cards >= MAX_CARDS) begin
            st = cac_pkg::ST_FULL;
          end else begin
            cards[n_cards] = it.card_code;
            n_cards++;
            st = cac_pkg::ST_ENROLLED;
          end
        end else if (is_listed(it.card_code)) begin
          st = cac_pkg::ST_KNOWN;
          if (ringing) silence();
          else armed = !armed;
        end else begin
          st = cac_pkg::ST_UNKNOWN;
        end
      end
      cac_pkg::ACT_TRIGGER: begin
        if (ringing) begin
          ring_count = '0;
          st = cac_pkg::ST_DONE;
        end else if (!armed && (locked || enrolling)) begin
          st = cac_pkg::ST_REFUSED;
        end else begin
          armed = 1'b1;
          if (buzzer_on) relay = 1'b1;
          ringing = 1'b1;
          ring_count = '0;
          st = cac_pkg::ST_DONE;
        end
      end
      cac_pkg::ACT_ARM: begin
        if (locked || enrolling) begin
          st = cac_pkg::ST_REFUSED;
        end else if (!armed) begin
          armed = 1'b1;
          st = cac_pkg::ST_DONE;
        end
      end
      cac_pkg::ACT_DISARM: begin
        if (locked) begin
          st = cac_pkg::ST_REFUSED;
        end else if (armed) begin
          silence();
          armed = 1'b0;
          st = cac_pkg::ST_DONE;
        end
      end
      cac_pkg::ACT_ENROL: begin
        if (locked || armed || enrolling) begin
          st = cac_pkg::ST_REFUSED;
        end else begin
          enrolling = 1'b1;
          st = cac_pkg::ST_DONE;
        end
      end
      cac_pkg::ACT_CLEAR: begin
        n_cards = '0;
        st = cac_pkg::ST_DONE;
      end
      default: ;
    endcase
    res.status        = st;
    res.armed_now     = armed;
    res.ringing_now   = ringing;
    res.relay_on      = relay;
    res.enrolling_now = enrolling;
    res.cards_held    = n_cards;
  endtask

  task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
    if (act !== exp) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp, act);
    end
  endtask

  // Outputs are read before the block's own updates at this edge take effect.
  always @(posedge clk) begin
    if (!rst_n) begin
      buzzer_on  = 1'b1;
      locked     = 1'b0;
      ring_limit = cac_pkg::TIMEOUT_RESET;
      armed      = 1'b0;
      ringing    = 1'b0;
      enrolling  = 1'b0;
      relay      = 1'b0;
      ring_count = '0;
      n_cards    = '0;
      pending_status.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_status.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing expected, actual %p", $time, out_data);
        end else begin
          oldest = pending_status.pop_front();
          check_field("status", 8'(oldest.status), 8'(out_data.status));
          check_field("armed_now", 8'(oldest.armed_now), 8'(out_data.armed_now));
          check_field("ringing_now", 8'(oldest.ringing_now), 8'(out_data.ringing_now));
          check_field("relay_on", 8'(oldest.relay_on), 8'(out_data.relay_on));
          check_field("enrolling_now", 8'(oldest.enrolling_now),
                      8'(out_data.enrolling_now));
          check_field("cards_held", 8'(oldest.cards_held), 8'(out_data.cards_held));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          cac_pkg::CFG_BUZZER:  buzzer_on  = cfg_wdata[0];
          cac_pkg::CFG_LOCK:    locked     = cfg_wdata[0];
          cac_pkg::CFG_TIMEOUT: ring_limit = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        apply_action(in_data, predicted);
        pending_status.push_back(predicted);
      end
    end
    queued = pending_status.size();
  end

endmodule

// File: tb/sv/card_armed_alarm_controller_unit_tb.sv
// Top of the card armed alarm controller testbench: clock, reset, stimulus,
// register phases and the verdict. Needs cac_pkg, the block and cac_alarm_checker.
module card_armed_alarm_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ACT_UNDEFINED = 3'd7;
  localparam int POOL_SIZE    = 40;
  localparam int PHASE_ITEMS  = 84;
  localparam int RANDOM_ITEMS = 6 * PHASE_ITEMS;
  localparam int HOLD_CYCLES  = 80;

  typedef enum int {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FULL} pace_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  cac_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  cac_pkg::out_item_t out_data;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = cac_pkg::CFG_BUZZER;
  logic [15:0]        cfg_wdata = '0;

  int          errors;
  int          queued;
  pace_t       pace = PACE_RX_SLOW;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          items_sent = 0;
  int          wait_cycles;
  logic [31:0] code_pool [POOL_SIZE];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  card_armed_alarm_controller_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cac_alarm_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .queued    (queued)
  );

  // Receiver: a requested hold-off keeps out_ready low while its counter runs
  // down, so that the input queue fills and in_ready drops.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (pace)
        PACE_RX_SLOW: out_ready <= ($urandom_range(0, 99) >= 57);
        PACE_TX_SLOW: out_ready <= ($urandom_range(0, 99) >= 12);
        default:      out_ready <= 1'b1;
      endcase
    end
  end

  function automatic int send_gap_pct();
    case (pace)
      PACE_RX_SLOW: return 12;
      PACE_TX_SLOW: return 57;
      default:      return 0;
    endcase
  endfunction

  // Valid stays high across back-to-back items and drops only for a gap.
  task automatic send_action(input logic [2:0] act, input logic [31:0] code);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {act, code};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (queued != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task automatic write_regs(input logic buz, input logic lock, input logic [15:0] limit);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= cac_pkg::CFG_BUZZER;
    cfg_wdata <= {15'd0, buz};
    @(negedge clk);
    cfg_index <= cac_pkg::CFG_LOCK;
    cfg_wdata <= {15'd0, lock};
    @(negedge clk);
    cfg_index <= cac_pkg::CFG_TIMEOUT;
    cfg_wdata <= limit;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_code();
    if ($urandom_range(0, 9) < 7) return code_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Mostly well-formed sequences: enrolment, ringing with timeout ticks and
  // arming by card, rare list clears, with single random actions as noise.
  task automatic random_burst();
    int pick;
    int n;
    logic [2:0] act;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_action(cac_pkg::ACT_DISARM, $urandom);
      send_action(cac_pkg::ACT_ENROL, $urandom);
      send_action(cac_pkg::ACT_CARD, pick_code());
    end else if (pick < 50) begin
      send_action(cac_pkg::ACT_TRIGGER, $urandom);
      n = $urandom_range(0, 6);
      repeat (n) send_action(cac_pkg::ACT_TICK, $urandom);
      if ($urandom_range(0, 1) == 1) send_action(cac_pkg::ACT_CARD, pick_code());
    end else if (pick < 60) begin
      send_action(cac_pkg::ACT_CARD, pick_code());
      send_action(cac_pkg::ACT_TRIGGER, $urandom);
    end else if (pick < 62) begin
      send_action(cac_pkg::ACT_CLEAR, $urandom);
    end else begin
      act = 3'($urandom_range(0, 6));
      // Clearing is kept rare so that the list can fill up.
      if (act == cac_pkg::ACT_CLEAR) act = ACT_UNDEFINED;
      send_action(act, (act == cac_pkg::ACT_CARD) ? pick_code() : $urandom);
    end
  endtask

  initial begin
    int p;
    int phase_end;
    code_pool[0] = 32'h0000_0000;
    code_pool[1] = 32'hFFFF_FFFF;
    for (p = 2; p < POOL_SIZE; p++) code_pool[p] = $urandom;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with the registers at their reset values.
    send_action(cac_pkg::ACT_TICK, 32'h0);
    send_action(ACT_UNDEFINED, 32'hFFFF_FFFF);
    send_action(cac_pkg::ACT_ARM, 32'h0);
    send_action(cac_pkg::ACT_ARM, 32'h0);
    send_action(cac_pkg::ACT_DISARM, 32'h0);
    send_action(cac_pkg::ACT_DISARM, 32'h0);
    send_action(cac_pkg::ACT_ENROL, 32'h0);
    send_action(cac_pkg::ACT_ENROL, 32'h0);
    send_action(cac_pkg::ACT_ARM, 32'h0);
    send_action(cac_pkg::ACT_TRIGGER, 32'h0);
    send_action(cac_pkg::ACT_CARD, 32'h0000_0000);
    send_action(cac_pkg::ACT_ENROL, 32'h0);
    send_action(cac_pkg::ACT_CARD, 32'h0000_0000);
    send_action(cac_pkg::ACT_ENROL, 32'h0);
    send_action(cac_pkg::ACT_CARD, 32'hFFFF_FFFF);
    send_action(cac_pkg::ACT_CARD, 32'h1234_5678);
    send_action(cac_pkg::ACT_CARD, 32'h0000_0000);
    send_action(cac_pkg::ACT_ENROL, 32'h0);
    send_action(cac_pkg::ACT_TRIGGER, 32'h0);
    send_action(cac_pkg::ACT_TRIGGER, 32'h0);
    send_action(cac_pkg::ACT_CARD, 32'hFFFF_FFFF);
    send_action(cac_pkg::ACT_CARD, 32'hFFFF_FFFF);
    send_action(cac_pkg::ACT_CLEAR, 32'h0);
    send_action(cac_pkg::ACT_CARD, 32'h0000_0000);
    send_action(cac_pkg::ACT_TRIGGER, 32'h0);

    // Buzzer disabled while ringing: the relay stays on after ringing stops.
    drain();
    write_regs(1'b0, 1'b0, cac_pkg::TIMEOUT_RESET);
    send_action(cac_pkg::ACT_DISARM, 32'h0);
    send_action(cac_pkg::ACT_TRIGGER, 32'h0);

    // Locked while ringing: only triggering and clearing still take effect.
    drain();
    write_regs(1'b1, 1'b1, 16'd0);
    send_action(cac_pkg::ACT_TICK, 32'h0);
    send_action(cac_pkg::ACT_TRIGGER, 32'h0);
    send_action(cac_pkg::ACT_CARD, 32'h0000_0000);
    send_action(cac_pkg::ACT_ARM, 32'h0);
    send_action(cac_pkg::ACT_DISARM, 32'h0);
    send_action(cac_pkg::ACT_ENROL, 32'h0);
    send_action(cac_pkg::ACT_CLEAR, 32'h0);

    // A zero timeout ends ringing on the first tick.
    drain();
    write_regs(1'b1, 1'b0, 16'd0);
    send_action(cac_pkg::ACT_TICK, 32'h0);
    send_action(cac_pkg::ACT_DISARM, 32'h0);

    items_sent = 0;
    for (p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: write_regs(1'b1, 1'b0, 16'd2);
        1: write_regs(1'b0, 1'b0, 16'd1);
        2: write_regs(1'b1, 1'b1, 16'd3);
        3: write_regs(1'b1, 1'b0, 16'hFFFF);
        4: write_regs(1'b0, 1'b0, 16'd5);
        default: write_regs(1'b1, 1'b0, 16'd1);
      endcase
      if (p == 1 || p == 4) hold_req++;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if (items_sent < RANDOM_ITEMS / 3) pace = PACE_RX_SLOW;
        else if (items_sent < 2 * RANDOM_ITEMS / 3) pace = PACE_TX_SLOW;
        else pace = PACE_FULL;
        random_burst();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (queued != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (25) @(negedge clk);
    if (queued != 0) $display("%0t: %0d expected results never arrived", $time, queued);
    if (errors == 0 && queued == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
